FILE: hdl/ooktx_pkg.sv
package ooktx_pkg;

  // Field widths of the stream items.
  localparam int unsigned SysW    = 5;
  localparam int unsigned LetterW = 8;
  localparam int unsigned RepW    = 8;
  localparam int unsigned DurW    = 16;
  localparam int unsigned CmdW    = 12;
  localparam int unsigned PulseW  = 6;
  localparam int unsigned CfgIdxW = 2;

  // Packed widths of the data buses, padded to whole bytes.
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 8;

  // Frame layout: four pulses per command bit, then a short pulse and the sync gap.
  localparam logic [PulseW-1:0] FramePulses = PulseW'(50);
  localparam logic [PulseW-1:0] LastBitEnd  = PulseW'(48);

  // Reset durations in ticks.
  localparam logic [DurW-1:0] ShortReset = DurW'(320);
  localparam logic [DurW-1:0] LongReset  = DurW'(960);
  localparam logic [DurW-1:0] GapReset   = DurW'(9920);

  // Unit letter range.
  localparam logic [LetterW-1:0] LetterFirst = 8'h41;
  localparam logic [LetterW-1:0] LetterLast  = 8'h45;

  // Register indexes on the configuration port.
  typedef enum logic [CfgIdxW-1:0] {
    REG_SHORT = 2'd0,
    REG_LONG  = 2'd1,
    REG_GAP   = 2'd2
  } reg_idx_t;

  // Item kinds carried in tuser.
  typedef enum logic {
    FUNC_TICK  = 1'b0,
    FUNC_START = 1'b1
  } func_t;

  // Pulse durations as seen by the engine.
  typedef struct packed {
    logic [DurW-1:0] short_ticks;
    logic [DurW-1:0] long_ticks;
    logic [DurW-1:0] gap_ticks;
  } dur_cfg_t;

  // One input item.
  typedef struct packed {
    func_t              func;
    logic [SysW-1:0]    sys_code;
    logic [LetterW-1:0] unit_letter;
    logic               switch_on;
    logic [RepW-1:0]    repeat_count;
  } item_t;

  // Builds the command word: system code, unit bit, then the two switch bits.
  function automatic logic [CmdW-1:0] build_cmd(logic [SysW-1:0] sys,
                                                logic [LetterW-1:0] letter,
                                                logic on);
    logic [CmdW-1:0]    cmd;
    logic [LetterW-1:0] offs;
    offs = letter - LetterFirst;
    cmd  = {sys, 7'b0};
    if (letter >= LetterFirst && letter <= LetterLast) begin
      cmd[3'd6 - offs[2:0]] = 1'b1;
    end
    cmd[1:0] = on ? 2'b10 : 2'b01;
    return cmd;
  endfunction

endpackage

FILE: hdl/ooktx_cfg_regs.sv
module ooktx_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ooktx_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [ooktx_pkg::DurW-1:0]     cfg_data,
  output ooktx_pkg::dur_cfg_t            dur_cfg
);
  import ooktx_pkg::*;

  dur_cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign dur_cfg   = cfg_r;

  // Register file; writes to an unused index are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.short_ticks <= ShortReset;
      cfg_r.long_ticks  <= LongReset;
      cfg_r.gap_ticks   <= GapReset;
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_SHORT: cfg_r.short_ticks <= cfg_data;
        REG_LONG:  cfg_r.long_ticks  <= cfg_data;
        REG_GAP:   cfg_r.gap_ticks   <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

FILE: hdl/ooktx_in_reg.sv
module ooktx_in_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  ooktx_pkg::item_t in_item,
  output logic             item_valid,
  output ooktx_pkg::item_t item,
  input  logic             item_take
);
  import ooktx_pkg::*;

  logic  valid_r;
  item_t item_r;

  // The stage refills in the same cycle that the engine takes its item.
  assign in_ready   = !valid_r || item_take;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

endmodule

FILE: hdl/ooktx_engine.sv
module ooktx_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  ooktx_pkg::dur_cfg_t dur_cfg,
  input  logic                item_valid,
  input  ooktx_pkg::item_t    item,
  output logic                item_take,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                line_level,
  output logic                busy_res
);
  import ooktx_pkg::*;

  // Transmitter state.
  logic              active_r, active_nxt;
  logic [CmdW-1:0]   cmd_r, cmd_nxt;
  logic [RepW-1:0]   reps_r, reps_nxt;
  logic [PulseW-1:0] pulse_r, pulse_nxt;
  logic [DurW-1:0]   tick_r, tick_nxt;

  // Result register.
  logic out_valid_r;
  logic line_r, line_nxt;
  logic busy_r, busy_nxt;

  logic              can_load;
  logic [DurW-1:0]   dur;
  logic [DurW-1:0]   tick_inc;
  logic [PulseW-1:0] pulse_inc;
  logic              cmd_bit;
  logic [3:0]        bit_sel;

  assign can_load  = !out_valid_r || out_ready;
  assign item_take = item_valid && can_load;

  assign out_valid  = out_valid_r;
  assign line_level = line_r;
  assign busy_res   = busy_r;

  // Duration of the running pulse: bit pulses follow the command bit, then a short pulse and the sync gap.
  assign bit_sel = 4'(CmdW - 1) - pulse_r[PulseW-1:2];
  assign cmd_bit = cmd_r[bit_sel];

  always_comb begin
    if (pulse_r < LastBitEnd) begin
      case (pulse_r[1:0])
        2'd0:    dur = dur_cfg.short_ticks;
        2'd1:    dur = dur_cfg.long_ticks;
        2'd2:    dur = cmd_bit ? dur_cfg.short_ticks : dur_cfg.long_ticks;
        default: dur = cmd_bit ? dur_cfg.long_ticks : dur_cfg.short_ticks;
      endcase
    end else if (pulse_r == LastBitEnd) begin
      dur = dur_cfg.short_ticks;
    end else begin
      dur = dur_cfg.gap_ticks;
    end
  end

  assign tick_inc  = tick_r + DurW'(1);
  assign pulse_inc = pulse_r + PulseW'(1);

  // One step of the transmitter per item.
  always_comb begin
    active_nxt = active_r;
    cmd_nxt    = cmd_r;
    reps_nxt   = reps_r;
    pulse_nxt  = pulse_r;
    tick_nxt   = tick_r;
    line_nxt   = active_r && !pulse_r[0];
    busy_nxt   = active_r;
    if (item.func == FUNC_START) begin
      // A start is taken only when idle and with frames to send.
      if (!active_r && item.repeat_count != '0) begin
        active_nxt = 1'b1;
        cmd_nxt    = build_cmd(item.sys_code, item.unit_letter, item.switch_on);
        reps_nxt   = item.repeat_count;
        pulse_nxt  = '0;
        tick_nxt   = '0;
        line_nxt   = 1'b1;
        busy_nxt   = 1'b1;
      end
    end else if (active_r) begin
      // A tick: count it, and move on when the pulse has run its length.
      tick_nxt = tick_inc;
      if (tick_inc >= dur || tick_inc == '0) begin
        tick_nxt  = '0;
        pulse_nxt = pulse_inc;
        if (pulse_inc >= FramePulses) begin
          pulse_nxt = '0;
          reps_nxt  = reps_r - RepW'(1);
          if (reps_r == RepW'(1)) begin
            active_nxt = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      cmd_r       <= '0;
      reps_r      <= '0;
      pulse_r     <= '0;
      tick_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (item_take) begin
        active_r <= active_nxt;
        cmd_r    <= cmd_nxt;
        reps_r   <= reps_nxt;
        pulse_r  <= pulse_nxt;
        tick_r   <= tick_nxt;
      end
      if (can_load) begin
        out_valid_r <= item_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      line_r <= line_nxt;
      busy_r <= busy_nxt;
    end
  end

  // The line is only driven high during a transmission.
  a_line_needs_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && line_r |-> busy_r)
    else $error("line high on a result that is not busy");

  // The pulse index stays inside the frame.
  a_pulse_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    pulse_r < FramePulses)
    else $error("pulse index beyond the frame");

  // While idle the pulse counters rest at zero.
  a_idle_counters: assert property (@(posedge clk) disable iff (!rst_n)
    !active_r |-> pulse_r == '0 && tick_r == '0)
    else $error("pulse counters not cleared while idle");

  // A running transmission always has a frame left to send.
  a_reps_left: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> reps_r != '0)
    else $error("active with no frames left");

  // A transmission can only end at the last pulse of a frame.
  a_end_at_gap: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(active_r) |-> $past(pulse_r) == FramePulses - PulseW'(1))
    else $error("transmission ended inside a frame");

endmodule

FILE: hdl/ook_remote_socket_transmitter_top.sv
// Encoder for fixed-code 433 MHz remote sockets. A start transaction (tuser = 1) loads a
// 12-bit command and a frame count; each tick transaction (tuser = 0) stands for one
// microsecond and returns the line level and busy flag for that tick, so the stream of
// results is the transmit waveform. Every input transaction gives exactly one result.
// One transaction per clock cycle is taken while out_tready does not stall the results,
// through an input register, then the transmitter state and result register, updated
// together. The user writes pulse durations through the configuration
// port while no transaction is in flight; the block does not enforce this. A write during
// a transmission acts at once, for the running pulse too; a start during one is ignored.
module ook_remote_socket_transmitter_top (
  input  logic                           clk,
  input  logic                           rst_n,
  // Input stream.
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // tdata: sys_code[4:0], unit_letter[12:5], switch_on[13], repeat_count[21:14]
  input  logic [ooktx_pkg::InDataW-1:0]  in_tdata,
  // tuser: func (0 tick, 1 start)
  input  logic                           in_tuser,
  // Result stream.
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // tdata: line_level[0], busy_res[1]
  output logic [ooktx_pkg::OutDataW-1:0] out_tdata,
  // Configuration writes.
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ooktx_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [ooktx_pkg::DurW-1:0]     cfg_data
);
  import ooktx_pkg::*;

  dur_cfg_t dur_cfg;
  item_t    in_item;
  item_t    item;
  logic     item_valid;
  logic     item_take;
  logic     line_level;
  logic     busy_res;

  // Unpack the input transaction.
  assign in_item.func         = func_t'(in_tuser);
  assign in_item.sys_code     = in_tdata[4:0];
  assign in_item.unit_letter  = in_tdata[12:5];
  assign in_item.switch_on    = in_tdata[13];
  assign in_item.repeat_count = in_tdata[21:14];

  assign out_tdata = {6'b0, busy_res, line_level};

  ooktx_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .dur_cfg   (dur_cfg)
  );

  ooktx_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  ooktx_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .dur_cfg    (dur_cfg),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .line_level (line_level),
    .busy_res   (busy_res)
  );

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import ooktx_pkg::*;

  localparam int CycleLimit = 2_000_000;
  localparam int PrintLimit = 100;

  // One result of the block: the line level and busy flag of a tick.
  typedef struct packed {
    logic busy;
    logic level;
  } line_sample_t;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata   = '0;
  logic                in_tuser   = 1'b0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;
  logic                cfg_valid  = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index  = '0;
  logic [DurW-1:0]     cfg_data   = '0;

  // Predicted transmitter state and pulse durations.
  logic [DurW-1:0]   dur_short;
  logic [DurW-1:0]   dur_long;
  logic [DurW-1:0]   dur_gap;
  logic              tx_active;
  logic [CmdW-1:0]   tx_cmd;
  logic [RepW-1:0]   frames_left;
  logic [PulseW-1:0] pulse_no;
  logic [DurW-1:0]   ticks_in_pulse;

  line_sample_t expected_line[$];
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;
  int           items_sent    = 0;
  int           error_count   = 0;
  int           cycle_count   = 0;

  ook_remote_socket_transmitter_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // Run limit in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("testbench NOT OK");
      $finish;
    end
  end

  // Prints one mismatch line, up to a limit, and counts every mismatch.
  task automatic report_mismatch(input string what, input logic [7:0] want,
                                 input logic [7:0] got);
    if (error_count < PrintLimit) begin
      $display("mismatch at cycle %0d: %s expected %0h, got %0h", cycle_count, what, want, got);
    end
    error_count++;
  endtask

  // Duration of a pulse of the running frame; a zero register acts as one tick.
  function automatic logic [DurW-1:0] pulse_len(input logic [PulseW-1:0] p);
    logic [DurW-1:0] d;
    logic            cmd_bit;
    if (p < LastBitEnd) begin
      cmd_bit = tx_cmd[CmdW - 1 - p[5:2]];
      case (p[1:0])
        2'd0: begin
          d = dur_short;
        end
        2'd1: begin
          d = dur_long;
        end
        2'd2: begin
          d = cmd_bit ? dur_short : dur_long;
        end
        default: begin
          d = cmd_bit ? dur_long : dur_short;
        end
      endcase
    end else if (p == LastBitEnd) begin
      d = dur_short;
    end else begin
      d = dur_gap;
    end
    return (d == '0) ? DurW'(1) : d;
  endfunction

  // Advances the predicted transmitter by one accepted item and queues its sample.
  task automatic step_waveform(input item_t it);
    line_sample_t s;
    logic [4:0]   unit_bits;
    if (it.func == FUNC_START && !tx_active && it.repeat_count != '0) begin
      unit_bits = (it.unit_letter >= LetterFirst && it.unit_letter <= LetterLast)
                  ? (5'b10000 >> (it.unit_letter - LetterFirst)) : 5'b00000;
      tx_cmd         = {it.sys_code, unit_bits, it.switch_on ? 2'b10 : 2'b01};
      frames_left    = it.repeat_count;
      pulse_no       = '0;
      ticks_in_pulse = '0;
      tx_active      = 1'b1;
    end
    s.busy  = tx_active;
    s.level = tx_active & ~pulse_no[0];
    if (it.func == FUNC_TICK && tx_active) begin
      ticks_in_pulse = ticks_in_pulse + DurW'(1);
      if (ticks_in_pulse >= pulse_len(pulse_no) || ticks_in_pulse == '0) begin
        ticks_in_pulse = '0;
        pulse_no       = pulse_no + PulseW'(1);
        if (pulse_no >= FramePulses) begin
          pulse_no    = '0;
          frames_left = frames_left - RepW'(1);
          if (frames_left == '0) begin
            tx_active = 1'b0;
          end
        end
      end
    end
    expected_line.push_back(s);
  endtask

  // Sends one item, with random idle cycles ahead of it, and predicts its result.
  task automatic send_item(input item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.func;
    in_tdata  <= {2'b00, it.repeat_count, it.switch_on, it.unit_letter, it.sys_code};
    do @(posedge clk); while (!in_tready);
    step_waveform(it);
    items_sent++;
  endtask

  function automatic item_t random_item(input func_t f);
    item_t it;
    it.func         = f;
    it.sys_code     = SysW'($urandom_range(31));
    it.unit_letter  = LetterW'($urandom_range(255));
    it.switch_on    = 1'($urandom_range(1));
    it.repeat_count = RepW'($urandom_range(255));
    return it;
  endfunction

  function automatic item_t start_item(input logic [SysW-1:0] sys,
                                       input logic [LetterW-1:0] letter,
                                       input logic on, input logic [RepW-1:0] reps);
    item_t it;
    it.func         = FUNC_START;
    it.sys_code     = sys;
    it.unit_letter  = letter;
    it.switch_on    = on;
    it.repeat_count = reps;
    return it;
  endfunction

  // Ticks until the predicted transmission is over.
  task automatic finish_transmission();
    while (tx_active) begin
      send_item(random_item(FUNC_TICK));
    end
  endtask

  // Holds the input low until every predicted result has arrived.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (expected_line.size() != 0);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [DurW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SHORT: begin
        dur_short = val;
      end
      REG_LONG: begin
        dur_long = val;
      end
      default: begin
        dur_gap = val;
      end
    endcase
  endtask

  // Writes all three durations once no transaction is in flight.
  task automatic write_durations(input logic [DurW-1:0] s, input logic [DurW-1:0] l,
                                 input logic [DurW-1:0] g);
    wait_drained();
    repeat (4) @(posedge clk);
    write_reg(REG_SHORT, s);
    write_reg(REG_LONG, l);
    write_reg(REG_GAP, g);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Writes all three durations once the transmitter and the pipeline are idle.
  task automatic apply_durations(input logic [DurW-1:0] s, input logic [DurW-1:0] l,
                                 input logic [DurW-1:0] g);
    finish_transmission();
    write_durations(s, l, g);
  endtask

  // Checks each result transaction against the oldest prediction.
  always @(posedge clk) begin : result_check
    line_sample_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_line.size() == 0) begin
        report_mismatch("result with none expected", 8'h00, out_tdata);
      end else begin
        want = expected_line.pop_front();
        if (out_tdata[0] !== want.level) begin
          report_mismatch("line_level", 8'(want.level), 8'(out_tdata[0]));
        end
        if (out_tdata[1] !== want.busy) begin
          report_mismatch("busy_res", 8'(want.busy), 8'(out_tdata[1]));
        end
      end
    end
    out_tready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  // Reset durations: idle ticks, a zero repeat count, the first two pulses of a frame and
  // a start while busy; shorter durations written in the middle of the long pulse then
  // take effect at once and the frame runs to its end.
  task automatic test_reset_defaults();
    repeat (3) send_item(random_item(FUNC_TICK));
    send_item(start_item(5'h00, LetterFirst, 1'b1, 8'd0));
    send_item(start_item(5'b10110, 8'h42, 1'b1, 8'd1));
    repeat (330) send_item(random_item(FUNC_TICK));
    send_item(start_item(5'h1F, LetterLast, 1'b0, 8'hFF));
    write_durations(16'd1, 16'd2, 16'd3);
    finish_transmission();
    repeat (2) send_item(random_item(FUNC_TICK));
  endtask

  // Each valid unit letter, letters outside the range, both system code extremes.
  task automatic test_unit_letters();
    logic [LetterW-1:0] letters [9] = '{8'h41, 8'h42, 8'h43, 8'h44, 8'h45,
                                        8'h40, 8'h46, 8'h00, 8'hFF};
    apply_durations(16'd1, 16'd2, 16'd3);
    for (int i = 0; i < 9; i++) begin
      send_item(start_item(i[0] ? 5'h1F : 5'h00, letters[i], i[1], 8'd1));
      finish_transmission();
    end
  endtask

  // Zero durations give one-tick pulses over several frames; a start while busy is ignored.
  task automatic test_zero_durations();
    apply_durations(16'd0, 16'd0, 16'd0);
    send_item(start_item(5'h15, 8'h43, 1'b0, 8'd3));
    repeat (60) send_item(random_item(FUNC_TICK));
    send_item(start_item(5'h0A, 8'h41, 1'b1, 8'd3));
    finish_transmission();
  endtask

  // The frame runs into the largest sync gap, which is then shortened while it runs;
  // the largest short and long values are written while idle.
  task automatic test_duration_extremes();
    apply_durations(16'd1, 16'd1, 16'hFFFF);
    send_item(start_item(5'h0A, 8'h44, 1'b1, 8'd1));
    repeat (80) send_item(random_item(FUNC_TICK));
    write_durations(16'd1, 16'd1, 16'd40);
    finish_transmission();
    apply_durations(16'hFFFF, 16'hFFFF, 16'd1);
    repeat (3) send_item(random_item(FUNC_TICK));
    send_item(start_item(5'h11, 8'h45, 1'b0, 8'd0));
    repeat (3) send_item(random_item(FUNC_TICK));
  endtask

  function automatic logic [LetterW-1:0] pick_letter();
    if ($urandom_range(99) < 75) begin
      return LetterFirst + LetterW'($urandom_range(4));
    end
    return LetterW'($urandom_range(255));
  endfunction

  function automatic logic [RepW-1:0] pick_reps();
    int r;
    r = $urandom_range(99);
    return (r < 80) ? 8'd1 : (r < 95) ? 8'd2 : 8'd3;
  endfunction

  // Mostly complete transmissions with random content, plus noise and partly ticked transmissions.
  task automatic test_random_traffic(input int n_items, input int send_pct, input int recv_pct);
    int    stop_at;
    int    kind;
    int    seq_no;
    int    pause_at;
    int    k;
    item_t it;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    apply_durations(DurW'($urandom_range(0, 2)), DurW'($urandom_range(1, 3)),
                    DurW'($urandom_range(0, 6)));
    stop_at = items_sent + n_items;
    seq_no  = 0;
    while (items_sent < stop_at) begin
      kind = $urandom_range(99);
      if (kind < 75) begin
        // Full transmission; now and then the sender holds off until all results are in.
        pause_at = (seq_no == 0 || $urandom_range(9) == 0) ? $urandom_range(1, 40) : -1;
        send_item(start_item(SysW'($urandom_range(31)), pick_letter(),
                             1'($urandom_range(1)), pick_reps()));
        k = 0;
        while (tx_active) begin
          k++;
          if (k == pause_at) begin
            wait_drained();
          end
          if ($urandom_range(99) < 3) begin
            send_item(random_item(FUNC_START));
          end else begin
            send_item(random_item(FUNC_TICK));
          end
        end
        repeat ($urandom_range(0, 3)) send_item(random_item(FUNC_TICK));
        seq_no++;
      end else if (kind < 85) begin
        it = random_item(FUNC_START);
        it.repeat_count = '0;
        send_item(it);
      end else if (kind < 93) begin
        // Transmission only partly ticked before the next kind is drawn; a start during it is ignored.
        send_item(start_item(SysW'($urandom_range(31)), LetterW'($urandom_range(255)),
                             1'($urandom_range(1)), pick_reps()));
        repeat ($urandom_range(1, 40)) send_item(random_item(FUNC_TICK));
      end else begin
        send_item(random_item(FUNC_TICK));
      end
    end
    send_idle_pct = 0;
  endtask

  initial begin
    dur_short      = ShortReset;
    dur_long       = LongReset;
    dur_gap        = GapReset;
    tx_active      = 1'b0;
    tx_cmd         = '0;
    frames_left    = '0;
    pulse_no       = '0;
    ticks_in_pulse = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_unit_letters();
    test_zero_durations();
    test_duration_extremes();
    test_random_traffic(160, 36, 63);
    test_random_traffic(160, 63, 36);
    test_random_traffic(160, 0, 0);

    finish_transmission();
    wait_drained();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
